// ===== rtl/core/pbce_pkg.sv =====
// Shared types and constants for the periodic Bezier curve evaluator.
// Used by the controller, the datapath and the top level.
package pbce_pkg;

  // Request command codes
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_EVAL   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  // Datapath operations issued by the controller each cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_SCAN,
    OP_LAST_RD,
    OP_LAST_LD,
    OP_SETUP,
    OP_DIV0,
    OP_DIV,
    OP_M_TAN,
    OP_T_ABS,
    OP_M_REC,
    OP_T_FIX,
    OP_M_LERP,
    OP_T_LERP,
    OP_FINAL
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] sel;
    logic       load_out;
  } ctl_t;

  typedef struct packed {
    logic cnt_zero;
    logic scan_done;
    logic need_last;
    logic dist_zero;
  } sts_t;

  // One control point as stored in the table
  typedef struct packed {
    logic        [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] left;
    logic signed [15:0] right;
  } pt_t;

  localparam int unsigned PT_W = 64;

  localparam logic signed [15:0] Y_ONE      = 16'sd16384;
  localparam logic [14:0]        TLIM_RESET = 15'h7FFF;
  // Half of 12288, for rounding the tangent third
  localparam logic [39:0]        THIRD_BIAS = 40'd6144;
  // floor(2^20 / 3)
  localparam logic signed [19:0] RECIP3     = 20'sd349525;
  localparam logic signed [39:0] LERP_HALF  = 40'sd32768;

  // Order of the six de Casteljau interpolations: slot written per step
  function automatic logic [1:0] lerp_sel(input logic [2:0] step);
    logic [1:0] s;
    case (step)
      3'd0:    s = 2'd0;
      3'd1:    s = 2'd1;
      3'd2:    s = 2'd2;
      3'd3:    s = 2'd0;
      3'd4:    s = 2'd1;
      default: s = 2'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/pbce_ram.sv =====
// Generic single write, single read RAM with registered read data.
// No dependencies.
module pbce_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/pbce_ctrl.sv =====
// Sequencer for the periodic Bezier curve evaluator.
// Depends on pbce_pkg; drives the datapath through ctl_t and reads sts_t.
module pbce_ctrl import pbce_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] cmd_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  sts_t       sts_i,
  output ctl_t       ctl_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_LAST_RD, S_LAST_LD, S_SETUP, S_DIV,
    S_M_TAN, S_T_ABS, S_M_REC, S_T_FIX, S_M_LERP, S_T_LERP,
    S_FINAL, S_RESP
  } state_e;

  localparam logic [4:0] DIV_LAST  = 5'd16;
  localparam logic [4:0] TAN_LAST  = 5'd1;
  localparam logic [4:0] LERP_LAST = 5'd5;

  state_e     state_q, state_d;
  logic [4:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  // Decode the datapath operation for this cycle
  always_comb begin
    ctl_o = '{op: OP_NONE, sel: 2'd0, load_out: 1'b0};
    case (state_q)
      S_IDLE:    ctl_o.op = accept ? OP_ACCEPT : OP_NONE;
      S_SCAN:    ctl_o.op = OP_SCAN;
      S_LAST_RD: ctl_o.op = OP_LAST_RD;
      S_LAST_LD: ctl_o.op = OP_LAST_LD;
      S_SETUP:   ctl_o.op = OP_SETUP;
      S_DIV:     ctl_o.op = (step_q == 5'd0) ? OP_DIV0 : OP_DIV;
      S_M_TAN: begin
        ctl_o.op  = OP_M_TAN;
        ctl_o.sel = step_q[1:0];
      end
      S_T_ABS:   ctl_o.op = OP_T_ABS;
      S_M_REC:   ctl_o.op = OP_M_REC;
      S_T_FIX: begin
        ctl_o.op  = OP_T_FIX;
        ctl_o.sel = step_q[1:0];
      end
      S_M_LERP: begin
        ctl_o.op  = OP_M_LERP;
        ctl_o.sel = lerp_sel(step_q[2:0]);
      end
      S_T_LERP: begin
        ctl_o.op  = OP_T_LERP;
        ctl_o.sel = lerp_sel(step_q[2:0]);
      end
      S_FINAL:   ctl_o.op = OP_FINAL;
      S_RESP:    ctl_o.load_out = out_free;
      default:   ctl_o.op = OP_NONE;
    endcase
  end

  // Next state
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((cmd_e'(cmd_i) == CMD_EVAL) && !sts_i.cnt_zero) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = sts_i.need_last ? S_LAST_RD : S_SETUP;
        end
      end
      S_LAST_RD: state_d = S_LAST_LD;
      S_LAST_LD: state_d = S_SETUP;
      S_SETUP: begin
        step_d  = 5'd0;
        state_d = sts_i.dist_zero ? S_RESP : S_DIV;
      end
      S_DIV: begin
        if (step_q == DIV_LAST) begin
          step_d  = 5'd0;
          state_d = S_M_TAN;
        end else begin
          step_d = step_q + 5'd1;
        end
      end
      S_M_TAN: state_d = S_T_ABS;
      S_T_ABS: state_d = S_M_REC;
      S_M_REC: state_d = S_T_FIX;
      S_T_FIX: begin
        if (step_q == TAN_LAST) begin
          step_d  = 5'd0;
          state_d = S_M_LERP;
        end else begin
          step_d  = step_q + 5'd1;
          state_d = S_M_TAN;
        end
      end
      S_M_LERP: state_d = S_T_LERP;
      S_T_LERP: begin
        if (step_q == LERP_LAST) begin
          state_d = S_FINAL;
        end else begin
          step_d  = step_q + 5'd1;
          state_d = S_M_LERP;
        end
      end
      S_FINAL: state_d = S_RESP;
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= 5'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load_out |=> out_valid_q)
    else $error("result load did not raise out_valid");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("request accepted without leaving idle");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_M_LERP || state_q == S_T_LERP) |-> (step_q <= LERP_LAST))
    else $error("interpolation step out of range");

endmodule

// ===== rtl/core/pbce_dp.sv =====
// Datapath: point table, segment search, divider, shared multiplier, output.
// Depends on pbce_pkg and pbce_ram.
module pbce_dp import pbce_pkg::*; #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctl_t               ctl_i,
  output sts_t               sts_o,
  input  logic               cfg_we_i,
  input  logic [14:0]        cfg_wdata_i,
  input  logic [1:0]         cmd_i,
  input  logic [15:0]        pos_x_i,
  input  logic signed [15:0] point_y_i,
  input  logic signed [15:0] left_slope_i,
  input  logic signed [15:0] right_slope_i,
  output logic signed [15:0] curve_value_o,
  output logic               accepted_o
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_POINTS);

  // Control state
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          vld_q, vld_d;
  logic [14:0]   tlim_q;

  // Payload state
  logic [15:0]        qx_q;
  pt_t                a_q, b_q, prev_q, first_q;
  logic [16:0]        dist_q;
  logic [17:0]        rem_q;
  logic [16:0]        quot_q;
  logic [16:0]        yd_q;
  logic signed [39:0] prod_q;
  logic [18:0]        v_q;
  logic               neg_q;
  logic signed [19:0] y0_q, y1_q, y2_q, y3_q;
  logic signed [15:0] res_val_q;
  logic               res_ok_q;
  logic signed [15:0] curve_value_q;
  logic               accepted_q;

  // Table RAM
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  pt_t           wr_pt, rd_pt;
  logic [PT_W-1:0] ram_rdata;

  pbce_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_pt),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );
  assign rd_pt = pt_t'(ram_rdata);

  // Clamp an appended point
  logic               full;
  logic signed [16:0] lim_p, lim_n, sl_l, sl_r, cl_l, cl_r;
  logic signed [15:0] cl_y;

  always_comb begin
    lim_p = $signed({2'b00, tlim_q});
    lim_n = -lim_p;
    sl_l  = 17'(left_slope_i);
    sl_r  = 17'(right_slope_i);
    cl_l  = (sl_l > lim_p) ? lim_p : ((sl_l < lim_n) ? lim_n : sl_l);
    cl_r  = (sl_r > lim_p) ? lim_p : ((sl_r < lim_n) ? lim_n : sl_r);
    cl_y  = (point_y_i > Y_ONE) ? Y_ONE : ((point_y_i < -Y_ONE) ? -Y_ONE : point_y_i);
    wr_pt = '{x: pos_x_i, y: cl_y, left: cl_l[15:0], right: cl_r[15:0]};
  end

  assign full      = (cnt_q >= CNT_MAX);
  assign ram_we    = (ctl_i.op == OP_ACCEPT) && (cmd_e'(cmd_i) == CMD_APPEND) && !full;
  assign ram_waddr = cnt_q[AW-1:0];

  // Segment search over the table
  logic          hit, last, issue, at_first;
  logic [CW-1:0] cnt_m1;

  assign hit      = vld_q && (rd_pt.x > qx_q);
  assign last     = vld_q && !hit && (idx_q == cnt_q);
  assign issue    = !hit && (idx_q < cnt_q);
  assign at_first = (idx_q == CW'(1));
  assign cnt_m1   = cnt_q - CW'(1);
  assign ram_re   = ((ctl_i.op == OP_SCAN) && issue) || (ctl_i.op == OP_LAST_RD);
  assign ram_raddr = (ctl_i.op == OP_LAST_RD) ? cnt_m1[AW-1:0] : idx_q[AW-1:0];

  // Segment geometry
  logic               wrapped;
  logic [16:0]        seg_dist;
  logic signed [17:0] num_s, dist_s;
  logic [16:0]        num_c;
  logic signed [16:0] ydiff;
  logic [16:0]        yabs;

  always_comb begin
    wrapped = a_q.x > b_q.x;
    if (wrapped) begin
      seg_dist = {1'b0, b_q.x} + 17'h10000 - {1'b0, a_q.x};
    end else begin
      seg_dist = {1'b0, b_q.x} - {1'b0, a_q.x};
    end
    if (wrapped && (qx_q < a_q.x)) begin
      num_s = $signed({2'b00, qx_q}) + 18'sd65536 - $signed({2'b00, a_q.x});
    end else begin
      num_s = $signed({2'b00, qx_q}) - $signed({2'b00, a_q.x});
    end
    dist_s = $signed({1'b0, seg_dist});
    if (num_s < 0) begin
      num_c = 17'd0;
    end else if (num_s > dist_s) begin
      num_c = seg_dist;
    end else begin
      num_c = num_s[16:0];
    end
    ydiff = 17'(b_q.y) - 17'(a_q.y);
    yabs  = ydiff[16] ? 17'(-ydiff) : 17'(ydiff);
  end

  // Divider step
  logic [17:0] div_sh;
  logic        div_ge;
  assign div_sh = (ctl_i.op == OP_DIV0) ? rem_q : {rem_q[16:0], 1'b0};
  assign div_ge = div_sh >= {1'b0, dist_q};

  // Shared multiplier operands
  logic signed [19:0] lo_y, hi_y;
  logic signed [19:0] mul_a, mul_b;

  always_comb begin
    case (ctl_i.sel)
      2'd0:    begin lo_y = y0_q; hi_y = y1_q; end
      2'd1:    begin lo_y = y1_q; hi_y = y2_q; end
      default: begin lo_y = y2_q; hi_y = y3_q; end
    endcase
    case (ctl_i.op)
      OP_M_TAN: begin
        mul_a = ctl_i.sel[0] ? 20'(b_q.left) : 20'(a_q.right);
        mul_b = $signed({3'b000, yd_q});
      end
      OP_M_REC: begin
        mul_a = $signed({1'b0, v_q});
        mul_b = RECIP3;
      end
      default: begin
        mul_a = hi_y - lo_y;
        mul_b = $signed({3'b000, quot_q});
      end
    endcase
  end

  // Tangent third, rounded half away from zero; rounded interpolation step; final clamp
  logic [39:0]        mag;
  logic [39:0]        mag_b;
  logic [18:0]        qe;
  logic [20:0]        rr;
  logic [18:0]        qf;
  logic signed [19:0] sv;
  logic signed [39:0] lr_rnd, lr_sh;
  logic signed [19:0] lr_new;
  logic signed [15:0] fin;

  always_comb begin
    mag    = prod_q[39] ? 40'(-prod_q) : 40'(prod_q);
    mag_b  = mag + THIRD_BIAS;
    qe     = prod_q[38:20];
    rr     = {2'b00, v_q} - (21'(qe) * 21'd3);
    qf     = qe + ((rr >= 21'd3) ? 19'd1 : 19'd0);
    sv     = neg_q ? -$signed({1'b0, qf}) : $signed({1'b0, qf});
    lr_rnd = prod_q + LERP_HALF;
    lr_sh  = lr_rnd >>> 16;
    lr_new = lo_y + lr_sh[19:0];
    if (y0_q > 20'(Y_ONE)) begin
      fin = Y_ONE;
    end else if (y0_q < -20'(Y_ONE)) begin
      fin = -Y_ONE;
    end else begin
      fin = y0_q[15:0];
    end
  end

  // Status to the controller
  assign sts_o = '{
    cnt_zero:  (cnt_q == '0),
    scan_done: hit || last,
    need_last: hit && at_first,
    dist_zero: (seg_dist == 17'd0)
  };

  // Control registers: count, scan index, limit
  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    vld_d = vld_q;
    case (ctl_i.op)
      OP_ACCEPT: begin
        idx_d = '0;
        vld_d = 1'b0;
        if (cmd_e'(cmd_i) == CMD_CLEAR) begin
          cnt_d = '0;
        end else if (ram_we) begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      OP_SCAN: begin
        vld_d = issue;
        idx_d = idx_q + (issue ? CW'(1) : CW'(0));
      end
      default: begin
        vld_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      idx_q  <= '0;
      vld_q  <= 1'b0;
      tlim_q <= TLIM_RESET;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
      vld_q <= vld_d;
      if (cfg_we_i) begin
        tlim_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      OP_ACCEPT: begin
        qx_q      <= pos_x_i;
        res_val_q <= '0;
        case (cmd_e'(cmd_i))
          CMD_CLEAR:  res_ok_q <= 1'b1;
          CMD_APPEND: res_ok_q <= !full;
          CMD_EVAL:   res_ok_q <= 1'b1;
          default:    res_ok_q <= 1'b0;
        endcase
      end
      OP_SCAN: begin
        if (vld_q && !hit) begin
          prev_q <= rd_pt;
          if (at_first) begin
            first_q <= rd_pt;
          end
        end
        if (hit) begin
          b_q <= rd_pt;
          if (!at_first) begin
            a_q <= prev_q;
          end
        end
        if (last) begin
          a_q <= rd_pt;
          b_q <= at_first ? rd_pt : first_q;
        end
      end
      OP_LAST_LD: a_q <= rd_pt;
      OP_SETUP: begin
        dist_q    <= seg_dist;
        rem_q     <= {1'b0, num_c};
        quot_q    <= '0;
        yd_q      <= yabs;
        y0_q      <= 20'(a_q.y);
        y3_q      <= 20'(b_q.y);
        res_val_q <= b_q.y;
      end
      OP_DIV0, OP_DIV: begin
        rem_q  <= div_ge ? (div_sh - {1'b0, dist_q}) : div_sh;
        quot_q <= {quot_q[15:0], div_ge};
      end
      OP_M_TAN, OP_M_REC, OP_M_LERP: begin
        prod_q <= mul_a * mul_b;
      end
      OP_T_ABS: begin
        v_q   <= mag_b[30:12];
        neg_q <= prod_q[39];
      end
      OP_T_FIX: begin
        if (ctl_i.sel[0]) begin
          y2_q <= 20'(b_q.y) - sv;
        end else begin
          y1_q <= 20'(a_q.y) + sv;
        end
      end
      OP_T_LERP: begin
        case (ctl_i.sel)
          2'd0:    y0_q <= lr_new;
          2'd1:    y1_q <= lr_new;
          default: y2_q <= lr_new;
        endcase
      end
      OP_FINAL: res_val_q <= fin;
      default: ;
    endcase
    if (ctl_i.load_out) begin
      curve_value_q <= res_val_q;
      accepted_q    <= res_ok_q;
    end
  end

  assign curve_value_o = curve_value_q;
  assign accepted_o    = accepted_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX)
    else $error("point count beyond table depth");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.op == OP_SCAN) |-> (idx_q <= cnt_q))
    else $error("scan index passed point count");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.op == OP_DIV0 || ctl_i.op == OP_DIV) |=> (rem_q < {1'b0, dist_q}))
    else $error("divider remainder not reduced");

endmodule

// ===== rtl/core/periodic_bezier_curve_evaluator.sv =====
// Channel   Direction  Handshake               Payload
// request   in         in_valid_i / in_stall_o  cmd, pos_x, point_y, left/right_slope
// result    out        out_valid_o/out_stall_i  curve_value, accepted
// config    in         cfg_we_i                 cfg_wdata_i (tangent limit)
//
// Clear, append and unused commands skip the scan and go straight to the result.
// Evaluate runs a table scan at one entry per cycle (with a read-back of the last
// point when the query lies before the first point), a 17-step restoring divider
// and 10 passes through one shared multiplier; a zero-width segment skips both.
// Reset empties the table and sets the tangent limit to its maximum.
// One request is in flight at a time; the result register frees the
// request side while a finished result waits on out_stall_i.
//
// Top level; depends on pbce_pkg, pbce_ctrl, pbce_dp and pbce_ram.
module periodic_bezier_curve_evaluator import pbce_pkg::*; #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic [15:0]        pos_x_i,
  input  logic signed [15:0] point_y_i,
  input  logic signed [15:0] left_slope_i,
  input  logic signed [15:0] right_slope_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] curve_value_o,
  output logic               accepted_o,
  input  logic               cfg_we_i,
  input  logic [14:0]        cfg_wdata_i
);

  ctl_t ctl;
  sts_t sts;

  pbce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  pbce_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd_i),
    .pos_x_i       (pos_x_i),
    .point_y_i     (point_y_i),
    .left_slope_i  (left_slope_i),
    .right_slope_i (right_slope_i),
    .curve_value_o (curve_value_o),
    .accepted_o    (accepted_o)
  );

endmodule

// ===== bench/tb_periodic_bezier_curve_evaluator.sv =====
// Self-checking bench for periodic_bezier_curve_evaluator: directed table then random
// point sets, each result checked against a behavioral curve predictor or a fixed value.
// Depends on pbce_pkg and the evaluator RTL.
module tb_periodic_bezier_curve_evaluator;
  import pbce_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NPTS = 16;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         cmd_i = CMD_CLEAR;
  logic [15:0]        pos_x_i = '0;
  logic signed [15:0] point_y_i = '0;
  logic signed [15:0] left_slope_i = '0;
  logic signed [15:0] right_slope_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] curve_value_o;
  logic               accepted_o;
  logic               cfg_we_i = 1'b0;
  logic [14:0]        cfg_wdata_i = '0;

  periodic_bezier_curve_evaluator #(.MAX_POINTS(NPTS)) u_dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  typedef struct {
    logic [1:0]         cmd;
    logic [15:0]        x;
    logic signed [15:0] y;
    logic signed [15:0] lt;
    logic signed [15:0] rt;
  } req_t;

  typedef struct {
    logic signed [15:0] value;
    logic               ok;
  } res_t;

  // Predictor state
  int          curve_x[NPTS];
  int          curve_y[NPTS];
  int          curve_l[NPTS];
  int          curve_r[NPTS];
  int unsigned curve_n;
  int          slope_lim;

  res_t        pending_res[$];
  bit          failed;
  bit          hold_off;
  int unsigned n_sent;

  function automatic longint fdiv(longint v, longint d);
    longint q;
    q = v / d;
    if ((v % d) != 0 && v < 0) q -= 1;
    return q;
  endfunction

  function automatic longint blend(longint p, longint q, longint t);
    return p + fdiv((q - p) * t + 32768, 65536);
  endfunction

  function automatic longint slope_third(longint tg, longint yd);
    longint p, m;
    p = tg * yd;
    m = p < 0 ? -p : p;
    m = (m + 6144) / 12288;
    return p < 0 ? -m : m;
  endfunction

  function automatic int clampi(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int curve_at(int q);
    int unsigned i, ia, ib;
    bit wrap;
    longint d, num, t, yd, y1, y2, p01, p12, p23, r0, r1, r;
    i = 0;
    if (curve_n == 0) return 0;
    while (i < curve_n && curve_x[i] <= q) i++;
    ib = (i >= curve_n) ? 0 : i;
    ia = (i == 0) ? curve_n - 1 : i - 1;
    wrap = curve_x[ia] > curve_x[ib];
    d = wrap ? longint'(curve_x[ib]) + 65536 - curve_x[ia] : curve_x[ib] - curve_x[ia];
    if (d <= 0) return curve_y[ib];
    num = (wrap && q < curve_x[ia]) ? 65536 - curve_x[ia] + q : longint'(q) - curve_x[ia];
    if (num < 0) num = 0;
    if (num > d) num = d;
    t = (num * 65536) / d;
    yd = curve_y[ib] - curve_y[ia];
    if (yd < 0) yd = -yd;
    y1 = curve_y[ia] + slope_third(curve_r[ia], yd);
    y2 = curve_y[ib] - slope_third(curve_l[ib], yd);
    p01 = blend(curve_y[ia], y1, t);
    p12 = blend(y1, y2, t);
    p23 = blend(y2, curve_y[ib], t);
    r0 = blend(p01, p12, t);
    r1 = blend(p12, p23, t);
    r = blend(r0, r1, t);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return int'(r);
  endfunction

  // Advance predictor state by one request and return its result
  function automatic res_t apply_request(req_t rq);
    res_t rs;
    rs.value = '0;
    rs.ok = 1'b1;
    case (rq.cmd)
      CMD_CLEAR: curve_n = 0;
      CMD_APPEND: begin
        if (curve_n >= NPTS) rs.ok = 1'b0;
        else begin
          curve_x[curve_n] = rq.x;
          curve_y[curve_n] = clampi(rq.y, -16384, 16384);
          curve_l[curve_n] = clampi(rq.lt, -slope_lim, slope_lim);
          curve_r[curve_n] = clampi(rq.rt, -slope_lim, slope_lim);
          curve_n++;
        end
      end
      CMD_EVAL: rs.value = 16'(curve_at(rq.x));
      default: rs.ok = 1'b0;
    endcase
    return rs;
  endfunction

  // Drive one request, wait for acceptance, queue its expected result.
  // Valid stays up after acceptance; a gap before the next request or a drain drops it.
  task automatic send_request(req_t rq, bit fixed, res_t want);
    res_t        rs;
    int unsigned gap;
    gap = $urandom_range(0, 14) * $urandom_range(0, 1);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= rq.cmd;
    pos_x_i <= rq.x;
    point_y_i <= rq.y;
    left_slope_i <= rq.lt;
    right_slope_i <= rq.rt;
    do @(posedge clk_i); while (in_stall_o);
    rs = apply_request(rq);
    if (fixed) rs = want;
    pending_res.push_back(rs);
    n_sent++;
  endtask

  task automatic drain_and_config(logic [14:0] lim);
    in_valid_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    slope_lim = lim;
  endtask

  function automatic req_t mk(logic [1:0] c, logic [15:0] x, int y, int l, int r);
    req_t rq;
    rq.cmd = c;
    rq.x = x;
    rq.y = 16'(y);
    rq.lt = 16'(l);
    rq.rt = 16'(r);
    return rq;
  endfunction

  function automatic req_t rand_req(logic [1:0] c, logic [15:0] x);
    req_t rq;
    rq.cmd = c;
    rq.x = x;
    rq.y = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
    rq.lt = 16'($urandom);
    rq.rt = 16'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      rq.lt = 16'($signed(rq.lt) >>> 4);
      rq.rt = 16'($signed(rq.rt) >>> 4);
    end
    return rq;
  endfunction

  // Result side: per-result wait drawn on acceptance, compare against oldest expectation
  initial begin
    res_t        want;
    int unsigned stall_cnt;
    stall_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_res.size() == 0) begin
          $display("%0t: unexpected result value %0d ok %0b", $time, curve_value_o,
                   accepted_o);
          failed = 1'b1;
        end else begin
          want = pending_res.pop_front();
          if (curve_value_o !== want.value) begin
            $display("%0t: curve_value expected %0d actual %0d", $time, want.value,
                     curve_value_o);
            failed = 1'b1;
          end
          if (accepted_o !== want.ok) begin
            $display("%0t: accepted expected %0b actual %0b", $time, want.ok, accepted_o);
            failed = 1'b1;
          end
        end
        stall_cnt = $urandom_range(0, 14);
      end else if (out_valid_o && stall_cnt != 0) begin
        stall_cnt--;
      end
      out_stall_i <= hold_off || (stall_cnt != 0);
    end
  end

  // Long receiver hold-off, counted here, while the sender keeps offering
  initial begin
    wait (n_sent == 600);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    #20ms;
    $display("[periodic_bezier_curve_evaluator] ERROR");
    $finish;
  end

  // Stimulus
  initial begin
    req_t  dir_rq[$];
    res_t  dir_res[$];
    bit    dir_fixed[$];
    res_t  r0, r1;
    int    npts, nq;
    logic [15:0] xs[NPTS];
    logic [14:0] lims[5];
    r0.value = '0; r0.ok = 1'b0;
    r1.value = '0; r1.ok = 1'b1;
    curve_n = 0;
    slope_lim = 32767;
    lims = '{15'd0, 15'd4096, 15'd32767, 15'd1000, 15'd12288};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: empty eval, unused code, extremes, single point, small tables
    dir_rq = '{mk(CMD_EVAL, 16'h0000, 0, 0, 0), mk(CMD_EVAL, 16'hFFFF, 0, 0, 0),
               mk(CMD_NOP, 16'hFFFF, -1, -1, -1), mk(CMD_APPEND, 16'h8000, 32767, 0, 0),
               mk(CMD_EVAL, 16'h0000, 0, 0, 0), mk(CMD_APPEND, 16'h8000, -32768, 0, 0),
               mk(CMD_EVAL, 16'h8000, 0, 0, 0), mk(CMD_CLEAR, 16'h0000, 0, 0, 0),
               mk(CMD_APPEND, 16'h0000, -16384, 32767, -32768),
               mk(CMD_APPEND, 16'hFFFF, 16384, -32768, 32767),
               mk(CMD_EVAL, 16'h0000, 0, 0, 0), mk(CMD_EVAL, 16'h7FFF, 0, 0, 0),
               mk(CMD_EVAL, 16'hFFFF, 0, 0, 0), mk(CMD_APPEND, 16'h1000, 0, 4096, 4096),
               mk(CMD_EVAL, 16'h0800, 0, 0, 0), mk(CMD_EVAL, 16'hFFFE, 0, 0, 0)};
    dir_fixed = '{1, 1, 1, 1, 1, 0, 1, 1, 1, 1, 0, 0, 0, 1, 0, 0};
    dir_res = '{r1, r1, r0, r1, r1, r1, r1, r1, r1, r1, r1, r1, r1, r1, r1, r1};
    dir_res[4].value = 16'sd16384;
    dir_res[6].value = 16'sd16384;
    foreach (dir_rq[k]) send_request(dir_rq[k], dir_fixed[k], dir_res[k]);
    // Fill past capacity: the extra appends are refused
    for (int k = 0; k < NPTS; k++)
      send_request(mk(CMD_APPEND, 16'(k * 4096), 0, 0, 0), 1'b0, r1);
    send_request(mk(CMD_EVAL, 16'h3000, 0, 0, 0), 1'b0, r1);

    // Random phases over several tangent limits
    for (int ph = 0; ph < 5; ph++) begin
      drain_and_config(lims[ph]);
      while (n_sent < 40 + (ph + 1) * 320) begin
        send_request(mk(CMD_CLEAR, 16'($urandom), 0, 0, 0), 1'b0, r1);
        npts = ($urandom_range(0, 7) == 0) ? NPTS + 2 : $urandom_range(1, 6);
        for (int k = 0; k < NPTS; k++) xs[k] = 16'($urandom);
        if ($urandom_range(0, 4) != 0) xs.sort();
        for (int k = 0; k < npts; k++)
          send_request(rand_req(CMD_APPEND, k < NPTS ? xs[k] : 16'($urandom)), 1'b0, r1);
        nq = $urandom_range(2, 8);
        for (int k = 0; k < nq; k++) begin
          if ($urandom_range(0, 15) == 0)
            send_request(rand_req(2'($urandom_range(0, 3)), 16'($urandom)), 1'b0, r1);
          else
            send_request(mk(CMD_EVAL, 16'($urandom), 0, 0, 0), 1'b0, r1);
        end
      end
    end

    in_valid_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (!failed) $display("[periodic_bezier_curve_evaluator] OK");
    else $display("[periodic_bezier_curve_evaluator] ERROR");
    $finish;
  end

endmodule
